[hdl/mlfq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types, codes and reset values of the feedback-queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

   localparam int DEF_NUM_SLOTS  = 64;
   localparam int DEF_NUM_LEVELS = 4;

   localparam int MODE_W     = 3;
   localparam int PSLOT_W    = 6;
   localparam int TICKS_W    = 8;
   localparam int LEVEL_W    = 2;
   localparam int QUANTUM_W  = 8;
   localparam int INTERVAL_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int MAX_LEVELS = 4;
   localparam int ATTR_W     = 4;

   localparam logic [MODE_W-1:0] MODE_MAKE_RUNNABLE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LEAVE         = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PICK          = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RUN_DONE      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TICK          = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM0       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM1       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM2       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM3       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST_INTERVAL = 3'd4;

   localparam logic [QUANTUM_W-1:0]  RST_QUANTUM0 = 8'd1;
   localparam logic [QUANTUM_W-1:0]  RST_QUANTUM1 = 8'd2;
   localparam logic [QUANTUM_W-1:0]  RST_QUANTUM2 = 8'd4;
   localparam logic [QUANTUM_W-1:0]  RST_QUANTUM3 = 8'd8;
   localparam logic [INTERVAL_W-1:0] RST_INTERVAL = 16'd100;

   typedef enum logic [1:0] {
      STAT_IDLE     = 2'd0,
      STAT_RUNNABLE = 2'd1,
      STAT_RUNNING  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ATTR,
      S_RULE,
      S_WALK,
      S_UPDATE,
      S_APP,
      S_PICK,
      S_PICK2,
      S_BOOST_INIT,
      S_BOOST,
      S_BOOST_END,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [MAX_LEVELS-1:0][QUANTUM_W-1:0] quantum;
      logic [INTERVAL_W-1:0]                interval;
   } cfg_type;

   typedef struct packed {
      logic               out_valid;
      logic [PSLOT_W-1:0] out_slot;
      logic [LEVEL_W-1:0] out_level;
      logic               boosted;
   } result_type;

endpackage
`default_nettype wire

[hdl/mlfq_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_ram
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mlfq_ram #(
   parameter int DEPTH = mlfq_pkg::DEF_NUM_SLOTS,
   parameter int WIDTH = mlfq_pkg::ATTR_W
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[hdl/mlfq_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer: slot attribute and link memories, queue heads and tails, list
// walk, boost sweep and the level rule.
// ----------------------------------------------------------------------------
module mlfq_ctrl #(
   parameter int NUM_SLOTS  = mlfq_pkg::DEF_NUM_SLOTS,
   parameter int NUM_LEVELS = mlfq_pkg::DEF_NUM_LEVELS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [mlfq_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [mlfq_pkg::PSLOT_W-1:0]   req_proc_slot,
   input  wire logic                           req_new_task,
   input  wire logic [mlfq_pkg::TICKS_W-1:0]   req_ticks_used,
   input  wire logic                           req_still_runnable,
   input  wire mlfq_pkg::cfg_type              cfg,
   output logic                                res_valid,
   input  wire logic                           res_take,
   output mlfq_pkg::result_type                res
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int LW = $clog2(NUM_SLOTS + 1);
   localparam int QW = $clog2(NUM_LEVELS);
   localparam logic [LW-1:0] LINK_NONE = LW'(NUM_SLOTS);
   localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

   mlfq_pkg::state_type state_ff, state_in;

   logic [mlfq_pkg::MODE_W-1:0]    mode_ff, mode_in;
   logic [SW-1:0]                  slot_ff, slot_in;
   logic                           fresh_ff, fresh_in;
   logic [mlfq_pkg::TICKS_W-1:0]   used_ff, used_in;
   logic                           keep_ff, keep_in;
   logic [mlfq_pkg::LEVEL_W-1:0]   lvl_ff, lvl_in;
   logic [mlfq_pkg::LEVEL_W-1:0]   nlvl_ff, nlvl_in;
   logic [mlfq_pkg::LEVEL_W-1:0]   app_lvl_ff, app_lvl_in;
   logic [LW-1:0]                  cur_ff, cur_in;
   logic [LW-1:0]                  prev_ff, prev_in;
   logic [SW-1:0]                  idx_ff, idx_in;
   logic [QW-1:0]                  pq_ff, pq_in;
   logic [LW-1:0]                  head_ff [NUM_LEVELS];
   logic [LW-1:0]                  head_in [NUM_LEVELS];
   logic [LW-1:0]                  tail_ff [NUM_LEVELS];
   logic [LW-1:0]                  tail_in [NUM_LEVELS];
   logic [mlfq_pkg::INTERVAL_W-1:0] tsb_ff, tsb_in;
   logic [NUM_SLOTS-1:0]           attr_vld_ff, attr_vld_in;
   logic                           rd_vld_ff;
   mlfq_pkg::result_type           res_ff, res_in;

   logic                           a_we;
   logic [SW-1:0]                  a_waddr, a_raddr;
   logic [mlfq_pkg::ATTR_W-1:0]    a_wdata, a_rdata;
   logic                           l_we;
   logic [SW-1:0]                  l_waddr, l_raddr;
   logic [LW-1:0]                  l_wdata, l_rdata;

   mlfq_ram #(.DEPTH(NUM_SLOTS), .WIDTH(mlfq_pkg::ATTR_W)) u_attr (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   mlfq_ram #(.DEPTH(NUM_SLOTS), .WIDTH(LW)) u_link (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_waddr),
      .wr_data (l_wdata),
      .rd_addr (l_raddr),
      .rd_data (l_rdata)
   );

   // unwritten attribute entries read as idle, level 0
   mlfq_pkg::status_type           rd_status;
   logic [mlfq_pkg::LEVEL_W-1:0]   rd_level;
   assign rd_status = rd_vld_ff ? mlfq_pkg::status_type'(a_rdata[3:2]) : mlfq_pkg::STAT_IDLE;
   assign rd_level  = rd_vld_ff ? a_rdata[1:0] : '0;

   logic                           slot_ok, boost_due;
   logic [LW-1:0]                  slot_link;
   assign slot_ok   = (32'(req_proc_slot) < NUM_SLOTS);
   assign boost_due = (tsb_ff >= cfg.interval);
   assign slot_link = LW'(slot_ff);

   // level rule
   logic [mlfq_pkg::QUANTUM_W-1:0] q_sel;
   logic [mlfq_pkg::TICKS_W-1:0]   used1;
   logic [mlfq_pkg::QUANTUM_W:0]   half_q;
   logic                           demote, promote;
   logic [mlfq_pkg::LEVEL_W-1:0]   rule_lvl;
   always_comb begin
      q_sel   = cfg.quantum[rd_level];
      used1   = (used_ff == '0) ? mlfq_pkg::TICKS_W'(1) : used_ff;
      half_q  = (9'(q_sel) + 9'd1) >> 1;
      demote  = (used1 >= q_sel);
      promote = (9'(used1) < half_q) && (rd_level != '0);
      rule_lvl = rd_level;
      if (demote) begin
         if ((3'(rd_level) + 3'd1) < 3'(NUM_LEVELS)) begin
            rule_lvl = rd_level + 2'd1;
         end
      end else if (promote) begin
         rule_lvl = rd_level - 2'd1;
      end
   end

   // highest-priority (lowest-numbered) nonempty queue
   logic          pick_found;
   logic [QW-1:0] pick_q;
   always_comb begin
      pick_found = 1'b0;
      pick_q     = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (head_ff[i] != LINK_NONE) begin
            pick_found = 1'b1;
            pick_q     = QW'(i);
         end
      end
   end

   // final update values of a slot request
   logic [mlfq_pkg::LEVEL_W-1:0] upd_lvl;
   mlfq_pkg::status_type         upd_status;
   always_comb begin
      case (mode_ff)
         mlfq_pkg::MODE_MAKE_RUNNABLE: begin
            upd_lvl    = fresh_ff ? '0 : lvl_ff;
            upd_status = mlfq_pkg::STAT_RUNNABLE;
         end
         mlfq_pkg::MODE_RUN_DONE: begin
            upd_lvl    = nlvl_ff;
            upd_status = keep_ff ? mlfq_pkg::STAT_RUNNABLE : mlfq_pkg::STAT_IDLE;
         end
         default: begin
            upd_lvl    = lvl_ff;
            upd_status = mlfq_pkg::STAT_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == mlfq_pkg::S_IDLE);
   assign res_valid = (state_ff == mlfq_pkg::S_DONE);
   assign res       = res_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mlfq_pkg::S_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  mlfq_pkg::MODE_MAKE_RUNNABLE,
                  mlfq_pkg::MODE_LEAVE,
                  mlfq_pkg::MODE_RUN_DONE:
                     state_in = slot_ok ? mlfq_pkg::S_ATTR : mlfq_pkg::S_DONE;
                  mlfq_pkg::MODE_PICK:
                     state_in = boost_due ? mlfq_pkg::S_BOOST_INIT : mlfq_pkg::S_PICK;
                  default:
                     state_in = mlfq_pkg::S_DONE;
               endcase
            end
         end
         mlfq_pkg::S_ATTR: state_in = mlfq_pkg::S_RULE;
         mlfq_pkg::S_RULE: begin
            if (mode_ff == mlfq_pkg::MODE_RUN_DONE && rd_status == mlfq_pkg::STAT_IDLE) begin
               state_in = mlfq_pkg::S_DONE;
            end else if (rd_status == mlfq_pkg::STAT_RUNNABLE) begin
               state_in = mlfq_pkg::S_WALK;
            end else begin
               state_in = mlfq_pkg::S_UPDATE;
            end
         end
         mlfq_pkg::S_WALK: begin
            if (cur_ff == LINK_NONE || cur_ff == slot_link) begin
               state_in = mlfq_pkg::S_UPDATE;
            end
         end
         mlfq_pkg::S_UPDATE: begin
            state_in = (upd_status == mlfq_pkg::STAT_RUNNABLE) ? mlfq_pkg::S_APP
                                                                : mlfq_pkg::S_DONE;
         end
         mlfq_pkg::S_APP:        state_in = mlfq_pkg::S_DONE;
         mlfq_pkg::S_PICK:       state_in = pick_found ? mlfq_pkg::S_PICK2 : mlfq_pkg::S_DONE;
         mlfq_pkg::S_PICK2:      state_in = mlfq_pkg::S_DONE;
         mlfq_pkg::S_BOOST_INIT: state_in = mlfq_pkg::S_BOOST;
         mlfq_pkg::S_BOOST: begin
            if (idx_ff == LAST_SLOT) begin
               state_in = mlfq_pkg::S_BOOST_END;
            end
         end
         mlfq_pkg::S_BOOST_END:  state_in = mlfq_pkg::S_PICK;
         mlfq_pkg::S_DONE: begin
            if (res_take) begin
               state_in = mlfq_pkg::S_IDLE;
            end
         end
         default: state_in = mlfq_pkg::S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      mode_in    = mode_ff;
      slot_in    = slot_ff;
      fresh_in   = fresh_ff;
      used_in    = used_ff;
      keep_in    = keep_ff;
      lvl_in     = lvl_ff;
      nlvl_in    = nlvl_ff;
      app_lvl_in = app_lvl_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      idx_in     = idx_ff;
      pq_in      = pq_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      tsb_in     = tsb_ff;
      res_in     = res_ff;
      a_we       = 1'b0;
      a_waddr    = slot_ff;
      a_wdata    = '0;
      a_raddr    = slot_ff;
      l_we       = 1'b0;
      l_waddr    = slot_ff;
      l_wdata    = LINK_NONE;
      l_raddr    = SW'(cur_ff);

      case (state_ff)
         mlfq_pkg::S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               slot_in  = SW'(req_proc_slot);
               fresh_in = req_new_task;
               used_in  = req_ticks_used;
               keep_in  = req_still_runnable;
               res_in   = '0;
               if (req_mode == mlfq_pkg::MODE_TICK && tsb_ff != '1) begin
                  tsb_in = tsb_ff + 16'd1;
               end
            end
         end
         mlfq_pkg::S_RULE: begin
            lvl_in  = rd_level;
            nlvl_in = rule_lvl;
            res_in.out_level = rd_level;
            // a runnable slot sits in the queue of its level
            cur_in  = head_ff[QW'(rd_level)];
            prev_in = LINK_NONE;
            l_raddr = SW'(head_ff[QW'(rd_level)]);
         end
         mlfq_pkg::S_WALK: begin
            if (cur_ff != LINK_NONE) begin
               if (cur_ff == slot_link) begin
                  if (prev_ff == LINK_NONE) begin
                     head_in[QW'(lvl_ff)] = l_rdata;
                  end else begin
                     l_we    = 1'b1;
                     l_waddr = SW'(prev_ff);
                     l_wdata = l_rdata;
                  end
                  if (tail_ff[QW'(lvl_ff)] == slot_link) begin
                     tail_in[QW'(lvl_ff)] = prev_ff;
                  end
               end else begin
                  prev_in = cur_ff;
                  cur_in  = l_rdata;
                  l_raddr = SW'(l_rdata);
               end
            end
         end
         mlfq_pkg::S_UPDATE: begin
            a_we       = 1'b1;
            a_wdata    = {upd_status, upd_lvl};
            res_in.out_level = upd_lvl;
            app_lvl_in = upd_lvl;
            if (upd_status == mlfq_pkg::STAT_RUNNABLE) begin
               l_we = 1'b1;
            end
         end
         mlfq_pkg::S_APP: begin
            if (tail_ff[QW'(app_lvl_ff)] != LINK_NONE) begin
               l_we    = 1'b1;
               l_waddr = SW'(tail_ff[QW'(app_lvl_ff)]);
               l_wdata = slot_link;
            end else begin
               head_in[QW'(app_lvl_ff)] = slot_link;
            end
            tail_in[QW'(app_lvl_ff)] = slot_link;
         end
         mlfq_pkg::S_PICK: begin
            pq_in   = pick_q;
            cur_in  = head_ff[pick_q];
            l_raddr = SW'(head_ff[pick_q]);
         end
         mlfq_pkg::S_PICK2: begin
            head_in[pq_ff] = l_rdata;
            if (l_rdata == LINK_NONE) begin
               tail_in[pq_ff] = LINK_NONE;
            end
            a_we    = 1'b1;
            a_waddr = SW'(cur_ff);
            a_wdata = {mlfq_pkg::STAT_RUNNING, 2'(pq_ff)};
            res_in.out_valid = 1'b1;
            res_in.out_slot  = mlfq_pkg::PSLOT_W'(cur_ff);
            res_in.out_level = 2'(pq_ff);
         end
         mlfq_pkg::S_BOOST_INIT: begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
               head_in[i] = LINK_NONE;
               tail_in[i] = LINK_NONE;
            end
            idx_in  = '0;
            prev_in = LINK_NONE;
            a_raddr = '0;
            res_in.boosted = 1'b1;
         end
         mlfq_pkg::S_BOOST: begin
            // read of the next slot overlaps the update of this one
            a_raddr = idx_ff + SW'(1);
            idx_in  = idx_ff + SW'(1);
            a_waddr = idx_ff;
            a_wdata = {rd_status, 2'b00};
            a_we    = (rd_status != mlfq_pkg::STAT_IDLE);
            if (rd_status == mlfq_pkg::STAT_RUNNABLE) begin
               if (prev_ff == LINK_NONE) begin
                  head_in[0] = LW'(idx_ff);
               end else begin
                  l_we    = 1'b1;
                  l_waddr = SW'(prev_ff);
                  l_wdata = LW'(idx_ff);
               end
               prev_in = LW'(idx_ff);
            end
         end
         mlfq_pkg::S_BOOST_END: begin
            if (prev_ff != LINK_NONE) begin
               l_we    = 1'b1;
               l_waddr = SW'(prev_ff);
               l_wdata = LINK_NONE;
               tail_in[0] = prev_ff;
            end
            tsb_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      attr_vld_in = attr_vld_ff;
      if (a_we) begin
         attr_vld_in[a_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mlfq_pkg::S_IDLE;
         attr_vld_ff <= '0;
         tsb_ff      <= '0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= LINK_NONE;
            tail_ff[i] <= LINK_NONE;
         end
      end else begin
         state_ff    <= state_in;
         attr_vld_ff <= attr_vld_in;
         tsb_ff      <= tsb_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      slot_ff    <= slot_in;
      fresh_ff   <= fresh_in;
      used_ff    <= used_in;
      keep_ff    <= keep_in;
      lvl_ff     <= lvl_in;
      nlvl_ff    <= nlvl_in;
      app_lvl_ff <= app_lvl_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      idx_ff     <= idx_in;
      pq_ff      <= pq_in;
      res_ff     <= res_in;
      rd_vld_ff  <= attr_vld_ff[a_raddr];
   end

endmodule
`default_nettype wire

[hdl/mlfq_scheduler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_scheduler
// Multilevel feedback-queue scheduler: control registers, sequencer and
// result buffer.
// ----------------------------------------------------------------------------
// One request at a time; the request port is not ready while one is in
// progress. Tick, unused-mode and out-of-range requests go straight to the
// result; leave, make runnable and run done unlink the slot when it sits in
// its level queue, walking the link memory one entry a cycle. A pick that
// boosts first sweeps over all slots. A finished result moves to an output
// register, so the next request is taken while it waits.
module mlfq_scheduler #(
   parameter int NUM_SLOTS  = mlfq_pkg::DEF_NUM_SLOTS,
   parameter int NUM_LEVELS = mlfq_pkg::DEF_NUM_LEVELS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [mlfq_pkg::MODE_W-1:0]      req_mode,
   input  wire logic [mlfq_pkg::PSLOT_W-1:0]     req_proc_slot,
   input  wire logic                             req_new_task,
   input  wire logic [mlfq_pkg::TICKS_W-1:0]     req_ticks_used,
   input  wire logic                             req_still_runnable,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_out_valid,
   output logic      [mlfq_pkg::PSLOT_W-1:0]     rsp_out_slot,
   output logic      [mlfq_pkg::LEVEL_W-1:0]     rsp_out_level,
   output logic                                  rsp_boosted,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [mlfq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mlfq_pkg::CSR_DATA_W-1:0]  csr_data
);

   mlfq_pkg::cfg_type    cfg_ff, cfg_in;
   mlfq_pkg::result_type res, buf_ff, buf_in;
   logic                 res_valid, res_take;
   logic                 buf_vld_ff, buf_vld_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            mlfq_pkg::CSR_QUANTUM0:       cfg_in.quantum[0] = csr_data[7:0];
            mlfq_pkg::CSR_QUANTUM1:       cfg_in.quantum[1] = csr_data[7:0];
            mlfq_pkg::CSR_QUANTUM2:       cfg_in.quantum[2] = csr_data[7:0];
            mlfq_pkg::CSR_QUANTUM3:       cfg_in.quantum[3] = csr_data[7:0];
            mlfq_pkg::CSR_BOOST_INTERVAL: cfg_in.interval   = csr_data;
            default: begin
            end
         endcase
      end
   end

   mlfq_ctrl #(.NUM_SLOTS(NUM_SLOTS), .NUM_LEVELS(NUM_LEVELS)) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_proc_slot      (req_proc_slot),
      .req_new_task       (req_new_task),
      .req_ticks_used     (req_ticks_used),
      .req_still_runnable (req_still_runnable),
      .cfg                (cfg_ff),
      .res_valid          (res_valid),
      .res_take           (res_take),
      .res                (res)
   );

   // result is moved when the buffer is empty or drains this cycle
   assign res_take = res_valid && (!buf_vld_ff || rsp_ready);

   always_comb begin
      buf_in     = buf_ff;
      buf_vld_in = buf_vld_ff;
      if (rsp_ready) begin
         buf_vld_in = 1'b0;
      end
      if (res_take) begin
         buf_in     = res;
         buf_vld_in = 1'b1;
      end
   end

   assign rsp_valid     = buf_vld_ff;
   assign rsp_out_valid = buf_ff.out_valid;
   assign rsp_out_slot  = buf_ff.out_slot;
   assign rsp_out_level = buf_ff.out_level;
   assign rsp_boosted   = buf_ff.boosted;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quantum[0] <= mlfq_pkg::RST_QUANTUM0;
         cfg_ff.quantum[1] <= mlfq_pkg::RST_QUANTUM1;
         cfg_ff.quantum[2] <= mlfq_pkg::RST_QUANTUM2;
         cfg_ff.quantum[3] <= mlfq_pkg::RST_QUANTUM3;
         cfg_ff.interval   <= mlfq_pkg::RST_INTERVAL;
         buf_vld_ff        <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         buf_vld_ff <= buf_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule
`default_nettype wire

[test/mlfq_checker.sv]
// ----------------------------------------------------------------------------
// mlfq_checker
// Watches the request, response and CSR channels of the scheduler, tracks
// slot status, levels and level queues, and compares every response.
// ----------------------------------------------------------------------------
module mlfq_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_ready,
   input  wire logic [mlfq_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [mlfq_pkg::PSLOT_W-1:0]    req_proc_slot,
   input  wire logic                            req_new_task,
   input  wire logic [mlfq_pkg::TICKS_W-1:0]    req_ticks_used,
   input  wire logic                            req_still_runnable,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic                            rsp_out_valid,
   input  wire logic [mlfq_pkg::PSLOT_W-1:0]    rsp_out_slot,
   input  wire logic [mlfq_pkg::LEVEL_W-1:0]    rsp_out_level,
   input  wire logic                            rsp_boosted,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [mlfq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mlfq_pkg::CSR_DATA_W-1:0] csr_data,
   output int                                   fail_count,
   output int                                   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = mlfq_pkg::DEF_NUM_SLOTS;

   // Level queues kept as plain slot lists; same FIFO order as linked lists.
   mlfq_pkg::status_type slot_stat [NSLOT];
   logic [1:0]           slot_lvl [NSLOT];
   int unsigned          level_queue [4][$];
   logic [7:0]           quantum [4];
   logic [15:0]          interval;
   logic [15:0]          ticks_since;
   mlfq_pkg::result_type expected_rsp [$];

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   function automatic void drop_entry(input logic [5:0] s);
      for (int q = 0; q < 4; q++)
         for (int i = 0; i < level_queue[q].size(); i++)
            if (level_queue[q][i] == s) begin
               level_queue[q].delete(i);
               return;
            end
   endfunction

   function automatic mlfq_pkg::result_type schedule(input logic [2:0] mode,
         input logic [5:0] s, input logic fresh, input logic [7:0] ticks, input logic keep);
      mlfq_pkg::result_type r;
      int unsigned used, q;
      logic [1:0] lvl;
      r = '0;
      used = (ticks == 0) ? 1 : ticks;
      case (mode)
         mlfq_pkg::MODE_MAKE_RUNNABLE: begin
            drop_entry(s);
            if (fresh) slot_lvl[s] = '0;
            slot_stat[s] = mlfq_pkg::STAT_RUNNABLE;
            level_queue[slot_lvl[s]].push_back(s);
            r.out_level = slot_lvl[s];
         end
         mlfq_pkg::MODE_LEAVE: begin
            drop_entry(s);
            slot_stat[s] = mlfq_pkg::STAT_IDLE;
            r.out_level = slot_lvl[s];
         end
         mlfq_pkg::MODE_PICK: begin
            if (ticks_since >= interval) begin
               for (int l = 0; l < 4; l++) level_queue[l].delete();
               for (int i = 0; i < NSLOT; i++) begin
                  if (slot_stat[i] != mlfq_pkg::STAT_IDLE) slot_lvl[i] = '0;
                  if (slot_stat[i] == mlfq_pkg::STAT_RUNNABLE) level_queue[0].push_back(i);
               end
               ticks_since = '0;
               r.boosted = 1'b1;
            end
            for (int l = 0; l < 4; l++)
               if (level_queue[l].size() > 0) begin
                  s = 6'(level_queue[l].pop_front());
                  slot_stat[s] = mlfq_pkg::STAT_RUNNING;
                  r.out_valid = 1'b1;
                  r.out_slot = s;
                  r.out_level = slot_lvl[s];
                  break;
               end
         end
         mlfq_pkg::MODE_RUN_DONE: begin
            if (slot_stat[s] != mlfq_pkg::STAT_IDLE) begin
               lvl = slot_lvl[s];
               q = quantum[lvl];
               if (used >= q) begin
                  if (lvl != 2'd3) lvl++;
               end else if (used < (q + 1) / 2 && lvl != 2'd0) begin
                  lvl--;
               end
               slot_lvl[s] = lvl;
               drop_entry(s);
               if (keep) begin
                  slot_stat[s] = mlfq_pkg::STAT_RUNNABLE;
                  level_queue[lvl].push_back(s);
               end else begin
                  slot_stat[s] = mlfq_pkg::STAT_IDLE;
               end
            end
            r.out_level = slot_lvl[s];
         end
         mlfq_pkg::MODE_TICK: if (ticks_since != 16'hFFFF) ticks_since++;
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      mlfq_pkg::result_type want;
      if (reset) begin
         for (int i = 0; i < NSLOT; i++) begin
            slot_stat[i] = mlfq_pkg::STAT_IDLE;
            slot_lvl[i] = '0;
         end
         for (int l = 0; l < 4; l++) level_queue[l].delete();
         quantum[0] = mlfq_pkg::RST_QUANTUM0;
         quantum[1] = mlfq_pkg::RST_QUANTUM1;
         quantum[2] = mlfq_pkg::RST_QUANTUM2;
         quantum[3] = mlfq_pkg::RST_QUANTUM3;
         interval = mlfq_pkg::RST_INTERVAL;
         ticks_since = '0;
         expected_rsp.delete();
         fail_count = 0;
         pending_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mlfq_pkg::CSR_QUANTUM0, mlfq_pkg::CSR_QUANTUM1,
               mlfq_pkg::CSR_QUANTUM2, mlfq_pkg::CSR_QUANTUM3:
                  quantum[csr_index[1:0]] = csr_data[7:0];
               mlfq_pkg::CSR_BOOST_INTERVAL: interval = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report("response count", 1, 0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_out_valid !== want.out_valid)
                  report("out_valid", rsp_out_valid, want.out_valid);
               if (rsp_out_slot !== want.out_slot)
                  report("out_slot", rsp_out_slot, want.out_slot);
               if (rsp_out_level !== want.out_level)
                  report("out_level", rsp_out_level, want.out_level);
               if (rsp_boosted !== want.boosted)
                  report("boosted", rsp_boosted, want.boosted);
            end
         end
         if (req_valid && req_ready)
            expected_rsp.push_back(schedule(req_mode, req_proc_slot, req_new_task,
                                            req_ticks_used, req_still_runnable));
         pending_count = expected_rsp.size();
      end
   end
endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the feedback-queue scheduler: directed corner requests, then
// random task lifecycles across several quantum and boost settings.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic [mlfq_pkg::MODE_W-1:0] req_mode = '0;
   logic [mlfq_pkg::PSLOT_W-1:0] req_proc_slot = '0;
   logic req_new_task = 0;
   logic [mlfq_pkg::TICKS_W-1:0] req_ticks_used = '0;
   logic req_still_runnable = 0;
   logic rsp_valid, rsp_ready = 0;
   logic rsp_out_valid, rsp_boosted;
   logic [mlfq_pkg::PSLOT_W-1:0] rsp_out_slot;
   logic [mlfq_pkg::LEVEL_W-1:0] rsp_out_level;
   logic csr_valid = 0, csr_ready;
   logic [mlfq_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mlfq_pkg::CSR_DATA_W-1:0] csr_data = '0;
   int fail_count, pending_count;
   int cycle_count = 0;
   bit calm = 0;       // last stretch: no idling
   bit hold_rsp = 0;   // long receiver hold-off

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   mlfq_scheduler dut (.*);

   mlfq_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1000000) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus a long hold-off on request.
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_rsp) rsp_ready <= 0;
         else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 0;
            n = $urandom_range(1, 8);
            repeat (n - 1) @(posedge clock);
         end else rsp_ready <= 1;
      end
   end

   // Valid stays up after a transfer so the next item can follow directly;
   // drain() drops it.
   task automatic send(input logic [mlfq_pkg::MODE_W-1:0] m, input int s, input bit f,
                       input int t, input bit k);
      int n;
      if (!calm && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_proc_slot <= mlfq_pkg::PSLOT_W'(s);
      req_new_task <= f;
      req_ticks_used <= mlfq_pkg::TICKS_W'(t);
      req_still_runnable <= k;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(input logic [mlfq_pkg::CSR_IDX_W-1:0] idx, input int v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= mlfq_pkg::CSR_DATA_W'(v);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic set_policy(input int q0, input int q1, input int q2, input int q3,
                             input int iv);
      drain();
      write_csr(mlfq_pkg::CSR_QUANTUM0, q0);
      write_csr(mlfq_pkg::CSR_QUANTUM1, q1);
      write_csr(mlfq_pkg::CSR_QUANTUM2, q2);
      write_csr(mlfq_pkg::CSR_QUANTUM3, q3);
      write_csr(mlfq_pkg::CSR_BOOST_INTERVAL, iv);
      csr_valid <= 1'b0;
   endtask

   // Mostly plausible lifecycles over a small slot pool, some noise.
   task automatic random_burst(input int count, input int pool);
      int r, s;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         s = (r % 10 == 0) ? $urandom_range(0, 63) : $urandom_range(0, pool - 1);
         if (r < 25) send(mlfq_pkg::MODE_MAKE_RUNNABLE, s, 1'($urandom), $urandom,
                          1'($urandom));
         else if (r < 32) send(mlfq_pkg::MODE_LEAVE, s, 1'($urandom), $urandom,
                               1'($urandom));
         else if (r < 55) send(mlfq_pkg::MODE_PICK, $urandom, 1'($urandom), $urandom,
                               1'($urandom));
         else if (r < 77) send(mlfq_pkg::MODE_RUN_DONE, s, 1'($urandom),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 10),
                               $urandom_range(0, 3) != 0);
         else if (r < 97) send(mlfq_pkg::MODE_TICK, $urandom, 1'($urandom), $urandom,
                               1'($urandom));
         else send(mlfq_pkg::MODE_W'($urandom_range(5, 7)), $urandom, 1'($urandom),
                   $urandom, 1'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty pick, extremes, yield, idle run done, unused modes
      send(mlfq_pkg::MODE_PICK, 0, 1'b0, 0, 1'b0);
      send(mlfq_pkg::MODE_MAKE_RUNNABLE, 63, 1'b1, 255, 1'b1);
      send(mlfq_pkg::MODE_MAKE_RUNNABLE, 0, 1'b0, 0, 1'b0);
      send(mlfq_pkg::MODE_MAKE_RUNNABLE, 5, 1'b1, 0, 1'b0);
      send(mlfq_pkg::MODE_PICK, 63, 1'b1, 255, 1'b1);
      send(mlfq_pkg::MODE_MAKE_RUNNABLE, 63, 1'b0, 0, 1'b0);
      send(mlfq_pkg::MODE_PICK, 0, 1'b0, 0, 1'b0);
      send(mlfq_pkg::MODE_RUN_DONE, 0, 1'b0, 0, 1'b1);
      send(mlfq_pkg::MODE_RUN_DONE, 0, 1'b0, 255, 1'b1);
      send(mlfq_pkg::MODE_RUN_DONE, 0, 1'b0, 255, 1'b1);
      send(mlfq_pkg::MODE_RUN_DONE, 0, 1'b0, 255, 1'b1);
      send(mlfq_pkg::MODE_RUN_DONE, 0, 1'b0, 1, 1'b1);
      send(mlfq_pkg::MODE_RUN_DONE, 40, 1'b1, 3, 1'b1);
      send(mlfq_pkg::MODE_LEAVE, 5, 1'b1, 0, 1'b0);
      send(mlfq_pkg::MODE_LEAVE, 5, 1'b0, 0, 1'b0);
      send(mlfq_pkg::MODE_RUN_DONE, 63, 1'b1, 2, 1'b0);
      send(3'd5, 63, 1'b1, 255, 1'b1);
      send(3'd7, 0, 1'b0, 0, 1'b0);
      for (int i = 0; i < 4; i++) send(mlfq_pkg::MODE_PICK, 0, 1'b0, 0, 1'b0);
      set_policy(255, 255, 255, 255, 1);
      random_burst(150, 8);
      set_policy(1, 1, 1, 1, 65535);
      random_burst(150, 64);
      set_policy($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
                 $urandom_range(1, 16), $urandom_range(1, 20));
      fork
         random_burst(400, 16);
         begin
            repeat (50) @(posedge clock);
            hold_rsp = 1;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
      join
      set_policy(3, 5, 7, 9, 5);
      random_burst(400, 12);
      calm = 1;
      random_burst(300, 20);
      drain();
      if (fail_count == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end
endmodule

[filelist.f]
hdl/mlfq_pkg.sv
hdl/mlfq_ram.sv
hdl/mlfq_ctrl.sv
hdl/mlfq_scheduler.sv
test/mlfq_checker.sv
test/testbench.sv
